### rtl/assert_macros.svh
// Assertion macros shared by the polar-to-Cartesian block.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The condition holds at every clock edge out of reset.
`define LP2C_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("lp2c: invariant violated");

// The consequent holds at every edge where the antecedent holds.
`define LP2C_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lp2c: implication violated");

`else

`define LP2C_ASSERT_ALWAYS(lbl, cond)
`define LP2C_ASSERT_IMPLY(lbl, ante, cons)

`endif

`endif

### rtl/lp2c_pkg.sv
// Package for the lidar polar-to-Cartesian block: widths, elevation constants,
// the quarter-wave sine table builder and the inter-stage word types.
// Depends on nothing.
package lp2c_pkg;

    localparam int LASER_COUNT      = 16;
    localparam int LASER_W          = 4;
    localparam int RANGE_W          = 16;
    localparam int AZ_W             = 16;
    localparam int COORD_W          = 17;
    localparam int TRIG_W           = 16;
    localparam int ELEV_W           = 16;

    // Quarter-wave table depth, a power of two from 256 to 4096.
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH);

    // Fractional bits of the trig factors and of the product scalings.
    localparam int FRAC_W           = 15;
    localparam int XY_SHIFT         = 2 * FRAC_W;
    localparam int Z_SHIFT          = FRAC_W;

    localparam int RC_W             = RANGE_W + ELEV_W;
    localparam int XY_PROD_W        = RC_W + TRIG_W;
    localparam int Z_PROD_W         = RANGE_W + ELEV_W;

    // Exact full-scale value of a quarter turn, not stored in the table.
    localparam logic [TRIG_W-1:0] TRIG_FULL = TRIG_W'(1 << FRAC_W);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_HALF    = 64'd536870912;

    typedef logic signed [ELEV_W-1:0] elev_arr_t [LASER_COUNT];

    // Elevation sine and cosine in Q1.15, interleaved -15, +1, -13, +3 ... +15 degrees.
    localparam elev_arr_t ELEV_SIN = '{
        -16'sd8481,  16'sd572,  -16'sd7371, 16'sd1715,
        -16'sd6252,  16'sd2856, -16'sd5126, 16'sd3993,
        -16'sd3993,  16'sd5126, -16'sd2856, 16'sd6252,
        -16'sd1715,  16'sd7371, -16'sd572,  16'sd8481
    };

    localparam elev_arr_t ELEV_COS = '{
        16'sd31651, 16'sd32763, 16'sd31928, 16'sd32723,
        16'sd32166, 16'sd32643, 16'sd32365, 16'sd32524,
        16'sd32524, 16'sd32365, 16'sd32643, 16'sd32166,
        16'sd32723, 16'sd31928, 16'sd32763, 16'sd31651
    };

    typedef logic [TRIG_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

    // Q30 multiply with rounding.
    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        return (a * b + Q30_HALF) >> 30;
    endfunction

    // Sine of a Q30 angle in [0, pi/2] as Q30, Taylor series up to x^17.
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x2   = mul_q30(x, x);
        term = x;
        sum  = longint'(x);
        term = mul_q30(term, x2) / 64'd6;
        sum  = sum - longint'(term);
        term = mul_q30(term, x2) / 64'd20;
        sum  = sum + longint'(term);
        term = mul_q30(term, x2) / 64'd42;
        sum  = sum - longint'(term);
        term = mul_q30(term, x2) / 64'd72;
        sum  = sum + longint'(term);
        term = mul_q30(term, x2) / 64'd110;
        sum  = sum - longint'(term);
        term = mul_q30(term, x2) / 64'd156;
        sum  = sum + longint'(term);
        term = mul_q30(term, x2) / 64'd210;
        sum  = sum - longint'(term);
        term = mul_q30(term, x2) / 64'd272;
        sum  = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        return 64'(sum);
    endfunction

    // One quarter-wave entry in units of 1/32768, saturated to 32767.
    function automatic logic [TRIG_W-1:0] sine_entry(input int unsigned k);
        logic [63:0] th;
        logic [63:0] v;
        th = (64'(k) * HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
        v  = (sin_q30(th) * 64'd32768 + Q30_HALF) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return TRIG_W'(v);
    endfunction

    // Whole table, evaluated at elaboration only.
    function automatic sine_rom_t sine_rom_build();
        sine_rom_t rom;
        for (int unsigned k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

    // Word leaving the table look-up stage.
    typedef struct packed {
        logic [1:0]               quad;
        logic                     hi_full;
        logic [RANGE_W-1:0]       range;
        logic signed [ELEV_W-1:0] elev_sin;
        logic signed [ELEV_W-1:0] elev_cos;
        logic [TRIG_W-1:0]        sin_lo;
        logic [TRIG_W-1:0]        sin_hi;
    } lp2c_look_t;

    // Word leaving the first multiply stage.
    typedef struct packed {
        logic [RC_W-1:0]     rc;
        logic [TRIG_W-1:0]   sa_mag;
        logic [TRIG_W-1:0]   ca_mag;
        logic                sa_neg;
        logic                ca_neg;
        logic [Z_PROD_W-1:0] z_prod;
        logic                z_neg;
    } lp2c_fac_t;

    // Word leaving the second multiply stage.
    typedef struct packed {
        logic [XY_PROD_W-1:0] x_prod;
        logic [XY_PROD_W-1:0] y_prod;
        logic                 x_neg;
        logic                 y_neg;
        logic [Z_PROD_W-1:0]  z_prod;
        logic                 z_neg;
    } lp2c_prod_t;

endpackage

### rtl/lp2c_in_if.sv
// Input channel of the polar-to-Cartesian block: one lidar return per word.
// Depends on lp2c_pkg.
interface lp2c_in_if;
    logic                          valid;
    logic                          ready;
    logic [lp2c_pkg::LASER_W-1:0]  laser_index;
    logic [lp2c_pkg::RANGE_W-1:0]  range;
    logic [lp2c_pkg::AZ_W-1:0]     azimuth;

    modport source (output valid, output laser_index, output range, output azimuth,
                    input ready);
    modport sink   (input valid, input laser_index, input range, input azimuth,
                    output ready);
endinterface

### rtl/lp2c_out_if.sv
// Output channel of the polar-to-Cartesian block: one Cartesian point per word.
// Depends on lp2c_pkg.
interface lp2c_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [lp2c_pkg::COORD_W-1:0] x_coord;
    logic signed [lp2c_pkg::COORD_W-1:0] y_coord;
    logic signed [lp2c_pkg::COORD_W-1:0] z_coord;

    modport source (output valid, output x_coord, output y_coord, output z_coord,
                    input ready);
    modport sink   (input valid, input x_coord, input y_coord, input z_coord,
                    output ready);
endinterface

### rtl/lp2c_trig.sv
// Look-up stage: quarter-wave sine ROM read at two addresses, elevation lookup.
// Depends on lp2c_pkg and lp2c_in_if.
module lp2c_trig (
    input  logic                 clk,
    input  logic                 rst_n,
    lp2c_in_if.sink              pt_in,
    output logic                 look_valid,
    input  logic                 look_ready,
    output lp2c_pkg::lp2c_look_t look
);
    import lp2c_pkg::*;

    localparam sine_rom_t SINE_ROM = sine_rom_build();

    logic                   valid_reg;
    logic                   adv;
    logic [SINE_ADDR_W-1:0] lo_addr;
    logic [SINE_ADDR_W-1:0] hi_addr;
    lp2c_look_t             look_reg;

    // The stage takes a word when it is empty or its word moves on.
    assign pt_in.ready = !valid_reg || look_ready;
    assign adv         = pt_in.valid && pt_in.ready;

    // Table index is the top bits of the angle within the quadrant; the
    // complementary index wraps to zero for a full quarter turn.
    assign lo_addr = pt_in.azimuth[AZ_W-3 -: SINE_ADDR_W];
    assign hi_addr = SINE_ADDR_W'(0) - lo_addr;

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pt_in.ready)
        begin
            valid_reg <= pt_in.valid;
        end
    end

    // Registered ROM reads and elevation factors.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            look_reg.quad     <= pt_in.azimuth[AZ_W-1 -: 2];
            look_reg.hi_full  <= (lo_addr == '0);
            look_reg.range    <= pt_in.range;
            look_reg.elev_sin <= ELEV_SIN[pt_in.laser_index];
            look_reg.elev_cos <= ELEV_COS[pt_in.laser_index];
            look_reg.sin_lo   <= SINE_ROM[lo_addr];
            look_reg.sin_hi   <= SINE_ROM[hi_addr];
        end
    end

    assign look_valid = valid_reg;
    assign look       = look_reg;

endmodule

### rtl/lp2c_scale.sv
// Two multiply stages: range times elevation factors, then times azimuth trig.
// Depends on lp2c_pkg.
module lp2c_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 look_valid,
    output logic                 look_ready,
    input  lp2c_pkg::lp2c_look_t look,
    output logic                 prod_valid,
    input  logic                 prod_ready,
    output lp2c_pkg::lp2c_prod_t prod
);
    import lp2c_pkg::*;

    logic              fac_valid_reg;
    logic              fac_ready;
    lp2c_fac_t         fac_reg;
    logic              prod_valid_reg;
    lp2c_prod_t        prod_reg;
    logic [TRIG_W-1:0] lo_mag;
    logic [TRIG_W-1:0] hi_mag;
    logic [ELEV_W-1:0] se_mag;

    // Each stage advances when empty or when its word is taken.
    assign fac_ready  = !prod_valid_reg || prod_ready;
    assign look_ready = !fac_valid_reg || fac_ready;

    // Magnitudes of the azimuth sine and cosine and of the elevation sine.
    assign lo_mag = look.sin_lo;
    assign hi_mag = look.hi_full ? TRIG_FULL : look.sin_hi;
    assign se_mag = look.elev_sin[ELEV_W-1] ? ELEV_W'(-look.elev_sin)
                                            : ELEV_W'(look.elev_sin);

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fac_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            if (look_ready)
            begin
                fac_valid_reg <= look_valid;
            end
            if (fac_ready)
            begin
                prod_valid_reg <= fac_valid_reg;
            end
        end
    end

    // First multiply: range by elevation cosine and by elevation sine magnitude.
    always_ff @(posedge clk)
    begin
        if (look_valid && look_ready)
        begin
            fac_reg.rc     <= RC_W'(look.range) * RC_W'(unsigned'(look.elev_cos));
            fac_reg.sa_mag <= look.quad[0] ? hi_mag : lo_mag;
            fac_reg.ca_mag <= look.quad[0] ? lo_mag : hi_mag;
            fac_reg.sa_neg <= look.quad[1];
            fac_reg.ca_neg <= look.quad[1] ^ look.quad[0];
            fac_reg.z_prod <= Z_PROD_W'(look.range) * Z_PROD_W'(se_mag);
            fac_reg.z_neg  <= look.elev_sin[ELEV_W-1];
        end
    end

    // Second multiply: horizontal range by azimuth sine and cosine.
    always_ff @(posedge clk)
    begin
        if (fac_valid_reg && fac_ready)
        begin
            prod_reg.x_prod <= XY_PROD_W'(fac_reg.rc) * XY_PROD_W'(fac_reg.sa_mag);
            prod_reg.y_prod <= XY_PROD_W'(fac_reg.rc) * XY_PROD_W'(fac_reg.ca_mag);
            prod_reg.x_neg  <= fac_reg.sa_neg;
            prod_reg.y_neg  <= fac_reg.ca_neg;
            prod_reg.z_prod <= fac_reg.z_prod;
            prod_reg.z_neg  <= fac_reg.z_neg;
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

endmodule

### rtl/lp2c_round.sv
// Output stage: rounds magnitudes half away from zero, applies signs, holds the word.
// Depends on lp2c_pkg and lp2c_out_if.
module lp2c_round (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 prod_valid,
    output logic                 prod_ready,
    input  lp2c_pkg::lp2c_prod_t prod,
    lp2c_out_if.source           pt_out
);
    import lp2c_pkg::*;

    logic                      valid_reg;
    logic [XY_PROD_W-1:0]      x_sum;
    logic [XY_PROD_W-1:0]      y_sum;
    logic [Z_PROD_W-1:0]       z_sum;
    logic [COORD_W-1:0]        x_mag;
    logic [COORD_W-1:0]        y_mag;
    logic [COORD_W-1:0]        z_mag;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic signed [COORD_W-1:0] z_reg;

    // The output register refills when empty or when the receiver takes it.
    assign prod_ready = !valid_reg || pt_out.ready;

    // Round the magnitudes; no product can exceed the output range.
    assign x_sum = prod.x_prod + (XY_PROD_W'(1) << (XY_SHIFT - 1));
    assign y_sum = prod.y_prod + (XY_PROD_W'(1) << (XY_SHIFT - 1));
    assign z_sum = prod.z_prod + (Z_PROD_W'(1) << (Z_SHIFT - 1));
    assign x_mag = x_sum[XY_SHIFT +: COORD_W];
    assign y_mag = y_sum[XY_SHIFT +: COORD_W];
    assign z_mag = z_sum[Z_SHIFT +: COORD_W];

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (prod_ready)
        begin
            valid_reg <= prod_valid;
        end
    end

    // Signed coordinates.
    always_ff @(posedge clk)
    begin
        if (prod_valid && prod_ready)
        begin
            x_reg <= prod.x_neg ? -signed'(x_mag) : signed'(x_mag);
            y_reg <= prod.y_neg ? -signed'(y_mag) : signed'(y_mag);
            z_reg <= prod.z_neg ? -signed'(z_mag) : signed'(z_mag);
        end
    end

    assign pt_out.valid   = valid_reg;
    assign pt_out.x_coord = x_reg;
    assign pt_out.y_coord = y_reg;
    assign pt_out.z_coord = z_reg;

endmodule

### rtl/lidar_polar_to_cartesian_core.sv
// Sixteen-laser lidar return to Cartesian point converter, top level.
// Depends on lp2c_pkg, lp2c_in_if, lp2c_out_if, lp2c_trig, lp2c_scale,
// lp2c_round and assert_macros.svh.
//
// Usage: each word on pt_in is one return (laser index, raw range, azimuth in
// 1/65536 of a turn); each word on pt_out is the point x, y, z in range units,
// rounded half away from zero. Both channels move a word at a clock edge where
// valid and ready are both high.
// From the accepting edge to pt_out.valid a word passes, in order, the ROM
// read, the range-by-elevation multiply, the trig multiply and the rounding
// output register. Throughput is one word per cycle while pt_out.ready is
// high; every stage has its own valid bit.
// When the receiver holds ready low, the output word is held and the stages
// behind it keep filling until all four are occupied; only then does
// pt_in.ready fall. Nothing is dropped or repeated.
// Reset clears all valid bits at once; the sine table is a constant ROM, so
// words are accepted from the first cycle after reset.
module lidar_polar_to_cartesian_core (
    input  logic        clk,
    input  logic        rst_n,
    lp2c_in_if.sink     pt_in,
    lp2c_out_if.source  pt_out
);
    import lp2c_pkg::*;

    `include "assert_macros.svh"

    logic       look_valid;
    logic       look_ready;
    lp2c_look_t look;
    logic       prod_valid;
    logic       prod_ready;
    lp2c_prod_t prod;

    // Table look-up stage.
    lp2c_trig u_trig (
        .clk        (clk),
        .rst_n      (rst_n),
        .pt_in      (pt_in),
        .look_valid (look_valid),
        .look_ready (look_ready),
        .look       (look)
    );

    // Multiply stages.
    lp2c_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .look_valid (look_valid),
        .look_ready (look_ready),
        .look       (look),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod)
    );

    // Rounding and output register.
    lp2c_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod),
        .pt_out     (pt_out)
    );

    // Input back-pressure only when the whole pipeline is full and stalled.
    `LP2C_ASSERT_IMPLY(a_stall_only_when_full, !pt_in.ready, pt_out.valid && !pt_out.ready)

    // Horizontal coordinates never reach the most negative code.
    `LP2C_ASSERT_IMPLY(a_xy_in_range, pt_out.valid, (pt_out.x_coord != 17'h10000) && (pt_out.y_coord != 17'h10000))

    // Height is bounded by the steepest laser at full range.
    `LP2C_ASSERT_IMPLY(a_z_in_range, pt_out.valid, ($signed(pt_out.z_coord) <= 17'sd16962) && ($signed(pt_out.z_coord) >= -17'sd16962))

endmodule

### tb/tb_lidar_polar_to_cartesian_core.sv
// Self-checking testbench for lidar_polar_to_cartesian_core: lidar returns are driven in,
// and each point word that comes out is checked against a Cartesian point predicted here.
// Depends on lp2c_pkg, lp2c_in_if, lp2c_out_if and the block itself.
module tb_lidar_polar_to_cartesian_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lp2c_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_TICKS = 6;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_TICKS  = 300;
    localparam int SETTLE_TICKS = 8;
    localparam int PHASE_WORDS = 400;

    // Quadrants of the azimuth, taken from its two top bits.
    typedef enum logic [1:0] {
        QUAD_FIRST  = 2'd0,
        QUAD_SECOND = 2'd1,
        QUAD_THIRD  = 2'd2,
        QUAD_FOURTH = 2'd3
    } quadrant_e;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    // Predicts the point for each accepted return and holds the points still owed.
    class point_scoreboard;
        localparam longint unsigned QUARTER_PI_Q30 = 64'd1686629713;
        localparam longint unsigned HALF_LSB_Q30   = 64'd536870912;

        int          elev_sine[LASER_COUNT] = '{
            -8481, 572, -7371, 1715, -6252, 2856, -5126, 3993,
            -3993, 5126, -2856, 6252, -1715, 7371, -572, 8481
        };
        int          elev_cosine[LASER_COUNT] = '{
            31651, 32763, 31928, 32723, 32166, 32643, 32365, 32524,
            32524, 32365, 32643, 32166, 32723, 31928, 32763, 31651
        };
        longint      quarter_sine[SINE_TABLE_DEPTH];
        point_t      expected_points[$];
        int          mismatch_count;

        function new();
            longint unsigned angle;
            longint unsigned scaled;
            mismatch_count = 0;
            for (int k = 0; k < SINE_TABLE_DEPTH; k++)
            begin
                angle  = (longint'(k) * QUARTER_PI_Q30 + SINE_TABLE_DEPTH / 2)
                         / SINE_TABLE_DEPTH;
                scaled = (taylor_sine(angle) * 64'd32768 + HALF_LSB_Q30) >> 30;
                quarter_sine[k] = (scaled > 64'd32767) ? 32767 : longint'(scaled);
            end
        endfunction

        // Sine of a Q30 angle as Q30, odd Taylor terms up to the seventeenth power.
        function longint unsigned taylor_sine(longint unsigned angle);
            longint unsigned sq;
            longint unsigned term;
            longint          total;
            sq    = (angle * angle + HALF_LSB_Q30) >> 30;
            term  = angle;
            total = longint'(angle);
            for (int n = 1; n <= 8; n++)
            begin
                term = ((term * sq + HALF_LSB_Q30) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                begin
                    total = total - longint'(term);
                end
                else
                begin
                    total = total + longint'(term);
                end
            end
            return (total < 0) ? 64'd0 : longint'(total);
        endfunction

        // The full quarter turn lies past the table and is exactly one.
        function longint table_sine(int unsigned idx);
            return (idx >= SINE_TABLE_DEPTH) ? 64'sd32768 : quarter_sine[idx];
        endfunction

        // Divides by a power of two, rounding half away from zero.
        function longint round_away(longint v, int sh);
            longint half;
            half = longint'(1) << (sh - 1);
            if (v < 0)
            begin
                return -((-v + half) >> sh);
            end
            return (v + half) >> sh;
        endfunction

        function point_t cartesian_of(logic [LASER_W-1:0] laser,
                                      logic [RANGE_W-1:0] distance,
                                      logic [AZ_W-1:0] azim);
            quadrant_e   quad;
            int unsigned idx;
            longint      lo;
            longint      hi;
            longint      sa;
            longint      ca;
            longint      r;
            longint      px;
            longint      py;
            longint      pz;
            point_t      pt;
            quad = quadrant_e'(azim[15:14]);
            idx  = int'((longint'(azim[13:0]) * SINE_TABLE_DEPTH) >> 14);
            lo   = table_sine(idx);
            hi   = table_sine(SINE_TABLE_DEPTH - idx);
            r    = longint'(distance);
            case (quad)
                QUAD_FIRST:  begin sa = lo;  ca = hi;  end
                QUAD_SECOND: begin sa = hi;  ca = -lo; end
                QUAD_THIRD:  begin sa = -lo; ca = -hi; end
                default:     begin sa = -hi; ca = lo;  end
            endcase
            px = round_away(r * elev_cosine[laser] * sa, 30);
            py = round_away(r * elev_cosine[laser] * ca, 30);
            pz = round_away(r * elev_sine[laser], 15);
            pt.x = COORD_W'(px);
            pt.y = COORD_W'(py);
            pt.z = COORD_W'(pz);
            return pt;
        endfunction

        function void note_return(logic [LASER_W-1:0] laser, logic [RANGE_W-1:0] distance,
                                  logic [AZ_W-1:0] azim);
            expected_points.push_back(cartesian_of(laser, distance, azim));
        endfunction

        function void check_point(point_t got);
            point_t want;
            if (expected_points.size() == 0)
            begin
                $error("point word arrived with none outstanding: x %0d y %0d z %0d",
                       got.x, got.y, got.z);
                mismatch_count++;
                return;
            end
            want = expected_points.pop_front();
            if (got.x !== want.x)
            begin
                $error("x_coord differs: expected %0d, actual %0d", want.x, got.x);
                mismatch_count++;
            end
            if (got.y !== want.y)
            begin
                $error("y_coord differs: expected %0d, actual %0d", want.y, got.y);
                mismatch_count++;
            end
            if (got.z !== want.z)
            begin
                $error("z_coord differs: expected %0d, actual %0d", want.z, got.z);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    lp2c_in_if  in_ch ();
    lp2c_out_if out_ch ();

    lidar_polar_to_cartesian_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pt_in  (in_ch),
        .pt_out (out_ch)
    );

    point_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Offers one return, idling at random first, and waits until it is taken.
    task automatic send_return(input logic [LASER_W-1:0] laser,
                               input logic [RANGE_W-1:0] distance,
                               input logic [AZ_W-1:0] azim);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.laser_index <= laser;
        in_ch.range       <= distance;
        in_ch.azimuth     <= azim;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        sb.note_return(laser, distance, azim);
    endtask

    // Drops valid and waits until every point owed has come out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // A random return, weighted towards zero and full range and quadrant edges.
    task automatic send_random_return();
        logic [RANGE_W-1:0] distance;
        logic [AZ_W-1:0]    azim;
        distance = RANGE_W'($urandom);
        azim     = AZ_W'($urandom);
        case ($urandom_range(9))
            0: distance = '0;
            1: distance = '1;
            2: azim = {azim[15:14], 14'($urandom_range(3))};
            3: azim = {azim[15:14], 14'(16383 - $urandom_range(3))};
            default: ;
        endcase
        send_return(LASER_W'($urandom_range(LASER_COUNT - 1)), distance, azim);
    endtask

    // Result side: check each accepted word, then choose ready for the next edge.
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                sb.check_point('{out_ch.x_coord, out_ch.y_coord, out_ch.z_coord});
            end
            if (hold_seen != hold_asked)
            begin
                hold_seen = hold_asked;
                hold_left = HOLD_TICKS;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: too long without any word moving on either side ends the run.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence: reset, directed returns, then three random phases.
    initial
    begin
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.laser_index <= '0;
        in_ch.range       <= '0;
        in_ch.azimuth     <= '0;
        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every laser at full range, with the azimuth stepping round the turn.
        for (int k = 0; k < LASER_COUNT; k++)
        begin
            send_return(LASER_W'(k), '1, AZ_W'(k * 4096 + k));
        end
        // Zero range, the exact quarter turns and the ends of the azimuth field.
        send_return(4'd0, '0, 16'h1234);
        send_return(4'd15, '0, '1);
        send_return(4'd3, '1, 16'h4000);
        send_return(4'd12, '1, 16'h8000);
        send_return(4'd0, '1, 16'hC000);
        send_return(4'd15, '1, 16'hFFFF);
        send_return(4'd7, 16'd1, 16'h3FFF);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 34; recv_idle_pct = 46; end
                1: begin send_idle_pct = 46; recv_idle_pct = 34; end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // Long receiver hold while words keep coming, to fill the pipe.
                    hold_asked = hold_asked + 1;
                    for (int n = 0; n < 40; n++)
                    begin
                        send_random_return();
                    end
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                send_random_return();
            end
            wait_drained();
        end

        repeat (SETTLE_TICKS) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
